/* rtl/core/sca_pkg.sv */
package sca_pkg;

  localparam int NUM_CLASSES      = 8;
  localparam int BLOCKS_PER_CLASS = 4;
  localparam int TOTAL_BLOCKS     = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int BLK_W            = $clog2(TOTAL_BLOCKS);
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0]  LIST_END  = 4'd15;
  localparam logic [15:0] MIN_BYTES = 16'd16;
  localparam logic [15:0] MAX_BYTES = 16'd2048;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_FREE    = 2'd1;
  localparam logic [1:0] FN_QUERY   = 2'd2;
  localparam logic [1:0] FN_UNKNOWN = 2'd3;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_BAD_HANDLE = 3'd3,
    ST_NOT_IN_USE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_QUERY,
    OP_BAD_SIZE,
    OP_BAD_HANDLE
  } op_t;

  // classified request word handed from front to back
  typedef struct packed {
    op_t        op;
    logic [2:0] cls;
    logic [3:0] idx;
  } cmd_t;

endpackage

/* rtl/core/size_class_block_allocator_unit.sv */
// Size-class block allocator: eight power-of-two classes (16 to 2048 bytes),
// each with a LIFO free list of blocks addressed by a (class, index) handle.
// Request channel: a word is taken at a rising edge where start is high and
// busy is low. func selects allocate, free or query; req_size is used by
// allocate and query, handle_class / handle_index by free.
// Result channel: done is high for exactly one cycle per request, with the
// result word on the result ports during that cycle. Results come back in
// request order, one per request.
// The accepting edge writes the command queue, and the edge after it updates
// the pool and the result register and raises done.
// Throughput: one request per cycle; the pool state is a set of small
// register arrays, so a free-list pop or push is a single register update.
// The back end takes a queued word every cycle, so the two-word command
// queue never fills and busy stays low.
// Reset (rst, synchronous): every free list is rebuilt in index order and
// refilled, the tallies, byte statistics and done clear and the queue empties.
// The result side has no back-pressure: results are never held.
module size_class_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [15:0] req_size,
  input  logic [2:0]  handle_class,
  input  logic [3:0]  handle_index,
  output logic        done,
  output logic [2:0]  status,
  output logic [2:0]  class_id,
  output logic [3:0]  block_index,
  output logic [3:0]  class_free_count,
  output logic [31:0] class_alloc_total,
  output logic [31:0] class_free_total,
  output logic [15:0] usage_bytes,
  output logic [15:0] usage_bytes_max,
  output logic [47:0] alloc_bytes_total,
  output logic [47:0] freed_bytes_total
);
  import sca_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic push;
  logic back_valid;
  logic q_full;

  assign busy = q_full;
  assign push = start && !q_full;

  sca_front u_front (
    .func         (func),
    .req_size     (req_size),
    .handle_class (handle_class),
    .handle_index (handle_index),
    .cmd          (front_cmd)
  );

  sca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (front_cmd),
    .pop       (1'b1),
    .head_word (back_cmd),
    .not_empty (back_valid),
    .full      (q_full)
  );

  sca_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (back_valid),
    .cmd               (back_cmd),
    .done              (done),
    .status            (status),
    .class_id          (class_id),
    .block_index       (block_index),
    .class_free_count  (class_free_count),
    .class_alloc_total (class_alloc_total),
    .class_free_total  (class_free_total),
    .usage_bytes       (usage_bytes),
    .usage_bytes_max   (usage_bytes_max),
    .alloc_bytes_total (alloc_bytes_total),
    .freed_bytes_total (freed_bytes_total)
  );

endmodule

/* rtl/core/sca_front.sv */
module sca_front (
  input  logic [1:0]    func,
  input  logic [15:0]   req_size,
  input  logic [2:0]    handle_class,
  input  logic [3:0]    handle_index,
  output sca_pkg::cmd_t cmd
);
  import sca_pkg::*;

  logic [15:0] size_m1;
  logic [3:0]  cls_raw;
  logic        size_bad;

  // smallest class c with (16 << c) >= size, from the top set bit of size - 1
  always_comb begin
    size_m1 = req_size - 16'd1;
    cls_raw = 4'd0;
    for (int b = 4; b < 11; b++) begin
      if (size_m1[b]) begin
        cls_raw = 4'(b - 3);
      end
    end
    size_bad = (req_size == 16'd0) || (req_size > MAX_BYTES) ||
               (cls_raw >= 4'(NUM_CLASSES));
  end

  always_comb begin
    cmd.op  = OP_BAD_HANDLE;
    cmd.cls = 3'd0;
    cmd.idx = 4'd0;
    unique case (func) inside
      FN_ALLOC, FN_QUERY: begin
        if (size_bad) begin
          cmd.op = OP_BAD_SIZE;
        end else begin
          cmd.op  = (func == FN_ALLOC) ? OP_ALLOC : OP_QUERY;
          cmd.cls = cls_raw[2:0];
        end
      end
      FN_FREE: begin
        cmd.cls = handle_class;
        cmd.idx = handle_index;
        if ((32'(handle_class) >= 32'(NUM_CLASSES)) ||
            (handle_index >= 4'(BLOCKS_PER_CLASS))) begin
          cmd.op = OP_BAD_HANDLE;
        end else begin
          cmd.op = OP_FREE;
        end
      end
      default: begin
        cmd.op = OP_BAD_HANDLE;
      end
    endcase
  end

endmodule

/* rtl/core/sca_queue.sv */
module sca_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sca_pkg::cmd_t push_word,
  input  logic          pop,
  output sca_pkg::cmd_t head_word,
  output logic          not_empty,
  output logic          full
);
  import sca_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_word = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

/* rtl/core/sca_back.sv */
module sca_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  sca_pkg::cmd_t cmd,
  output logic          done,
  output logic [2:0]    status,
  output logic [2:0]    class_id,
  output logic [3:0]    block_index,
  output logic [3:0]    class_free_count,
  output logic [31:0]   class_alloc_total,
  output logic [31:0]   class_free_total,
  output logic [15:0]   usage_bytes,
  output logic [15:0]   usage_bytes_max,
  output logic [47:0]   alloc_bytes_total,
  output logic [47:0]   freed_bytes_total
);
  import sca_pkg::*;

  logic [3:0]  free_next   [TOTAL_BLOCKS];
  logic [3:0]  list_top    [NUM_CLASSES];
  logic [3:0]  free_blocks [NUM_CLASSES];
  logic [31:0] alloc_tally [NUM_CLASSES];
  logic [31:0] free_tally  [NUM_CLASSES];
  logic [TOTAL_BLOCKS-1:0] block_busy;
  logic [15:0] usage_now;
  logic [15:0] usage_peak;
  logic [47:0] bytes_alloc_sum;
  logic [47:0] bytes_freed_sum;

  logic [3:0]       head;
  logic [BLK_W-1:0] alloc_addr;
  logic [BLK_W-1:0] free_addr;
  logic [15:0]      bytes;
  logic [15:0]      usage_up;
  logic             do_alloc;
  logic             do_free;

  status_t     res_status;
  logic [2:0]  res_class;
  logic [3:0]  res_index;
  logic [3:0]  res_count;
  logic [31:0] res_alloc;
  logic [31:0] res_free;
  logic [15:0] usage_next;
  logic [15:0] peak_next;
  logic [47:0] alloc_sum_next;
  logic [47:0] freed_sum_next;

  always_comb begin
    head       = list_top[cmd.cls];
    alloc_addr = BLK_W'(cmd.cls) * BLK_W'(BLOCKS_PER_CLASS) + BLK_W'(head);
    free_addr  = BLK_W'(cmd.cls) * BLK_W'(BLOCKS_PER_CLASS) + BLK_W'(cmd.idx);
    bytes      = MIN_BYTES << cmd.cls;
    usage_up   = usage_now + bytes;

    do_alloc       = 1'b0;
    do_free        = 1'b0;
    res_status     = ST_OK;
    res_class      = 3'd0;
    res_index      = 4'd0;
    res_count      = 4'd0;
    res_alloc      = 32'd0;
    res_free       = 32'd0;
    usage_next     = usage_now;
    peak_next      = usage_peak;
    alloc_sum_next = bytes_alloc_sum;
    freed_sum_next = bytes_freed_sum;

    unique case (cmd.op)
      OP_ALLOC: begin
        res_class = cmd.cls;
        res_count = free_blocks[cmd.cls];
        res_alloc = alloc_tally[cmd.cls];
        res_free  = free_tally[cmd.cls];
        if ((free_blocks[cmd.cls] == 4'd0) || (head >= 4'(BLOCKS_PER_CLASS))) begin
          res_status = ST_EXHAUSTED;
        end else begin
          do_alloc       = 1'b1;
          res_index      = head;
          res_count      = free_blocks[cmd.cls] - 4'd1;
          res_alloc      = alloc_tally[cmd.cls] + 32'd1;
          usage_next     = usage_up;
          peak_next      = (usage_up > usage_peak) ? usage_up : usage_peak;
          alloc_sum_next = bytes_alloc_sum + 48'(bytes);
        end
      end
      OP_FREE: begin
        res_class = cmd.cls;
        res_index = cmd.idx;
        res_count = free_blocks[cmd.cls];
        res_alloc = alloc_tally[cmd.cls];
        res_free  = free_tally[cmd.cls];
        if (!block_busy[free_addr]) begin
          res_status = ST_NOT_IN_USE;
        end else begin
          do_free        = 1'b1;
          res_count      = free_blocks[cmd.cls] + 4'd1;
          res_free       = free_tally[cmd.cls] + 32'd1;
          usage_next     = usage_now - bytes;
          freed_sum_next = bytes_freed_sum + 48'(bytes);
        end
      end
      OP_QUERY: begin
        res_class = cmd.cls;
        res_count = free_blocks[cmd.cls];
        res_alloc = alloc_tally[cmd.cls];
        res_free  = free_tally[cmd.cls];
      end
      OP_BAD_SIZE: begin
        res_status = ST_BAD_SIZE;
      end
      OP_BAD_HANDLE: begin
        res_status = ST_BAD_HANDLE;
        res_class  = cmd.cls;
        res_index  = cmd.idx;
      end
      default: begin
        res_status = ST_BAD_HANDLE;
      end
    endcase

    if (!cmd_valid) begin
      do_alloc       = 1'b0;
      do_free        = 1'b0;
      usage_next     = usage_now;
      peak_next      = usage_peak;
      alloc_sum_next = bytes_alloc_sum;
      freed_sum_next = bytes_freed_sum;
    end
  end

  // pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        for (int i = 0; i < BLOCKS_PER_CLASS; i++) begin
          free_next[c * BLOCKS_PER_CLASS + i] <=
            (i + 1 < BLOCKS_PER_CLASS) ? 4'(i + 1) : LIST_END;
        end
        list_top[c]    <= 4'd0;
        free_blocks[c] <= 4'(BLOCKS_PER_CLASS);
        alloc_tally[c] <= 32'd0;
        free_tally[c]  <= 32'd0;
      end
      block_busy      <= '0;
      usage_now       <= 16'd0;
      usage_peak      <= 16'd0;
      bytes_alloc_sum <= 48'd0;
      bytes_freed_sum <= 48'd0;
    end else begin
      if (do_alloc) begin
        // pop the list head
        list_top[cmd.cls]      <= free_next[alloc_addr];
        free_blocks[cmd.cls]   <= res_count;
        alloc_tally[cmd.cls]   <= res_alloc;
        block_busy[alloc_addr] <= 1'b1;
      end
      if (do_free) begin
        // push the block back as the new head
        free_next[free_addr]  <= list_top[cmd.cls];
        list_top[cmd.cls]     <= cmd.idx;
        free_blocks[cmd.cls]  <= res_count;
        free_tally[cmd.cls]   <= res_free;
        block_busy[free_addr] <= 1'b0;
      end
      usage_now       <= usage_next;
      usage_peak      <= peak_next;
      bytes_alloc_sum <= alloc_sum_next;
      bytes_freed_sum <= freed_sum_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    status            <= res_status;
    class_id          <= res_class;
    block_index       <= res_index;
    class_free_count  <= res_count;
    class_alloc_total <= res_alloc;
    class_free_total  <= res_free;
    usage_bytes       <= usage_next;
    usage_bytes_max   <= peak_next;
    alloc_bytes_total <= alloc_sum_next;
    freed_bytes_total <= freed_sum_next;
  end

endmodule
